>>> hdl/kce_pkg.sv
// Shared constants, codes and types of the keyframe curve evaluator.
package kce_pkg;

   // Table geometry and fixed-point format.
   localparam int MAX_KEYS  = 64;
   localparam int KEY_AW    = $clog2(MAX_KEYS);
   localparam int CNT_W     = KEY_AW + 1;
   localparam int FRAC_BITS = 16;
   localparam int T_W       = FRAC_BITS + 1;
   localparam int TICK_W    = 32;
   localparam int VAL_W     = 32;
   localparam int CURVE_W   = 3;
   localparam int SRC_W     = 3;

   // Shared multiplier operand widths.
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = FRAC_BITS + 2;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Divider step counter.
   localparam int DIV_CNT_W = $clog2(T_W + 1);

   // Fixed-point constants.
   localparam logic [T_W-1:0]     ONE       = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [T_W-1:0]     HALF      = {2'b01, {(FRAC_BITS-1){1'b0}}};
   localparam logic [MUL_B_W-1:0] THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};

   // Port widths.
   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_AW      = 1;
   localparam int CSR_DW      = 32;

   // Command codes carried on req_tuser.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_AW-1:0] CSR_KEYS_IN_USE = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_EMPTY_LEVEL = 1'b1;

   // Curve modes.
   localparam logic [CURVE_W-1:0] CURVE_LINEAR      = 3'd0;
   localparam logic [CURVE_W-1:0] CURVE_EASE_IN     = 3'd1;
   localparam logic [CURVE_W-1:0] CURVE_EASE_OUT    = 3'd2;
   localparam logic [CURVE_W-1:0] CURVE_EASE_IN_OUT = 3'd3;
   localparam logic [CURVE_W-1:0] CURVE_SMOOTHSTEP  = 3'd4;
   localparam logic [CURVE_W-1:0] CURVE_HOLD        = 3'd5;

   // Result source codes.
   localparam logic [SRC_W-1:0] SRC_DEFAULT = 3'd0;
   localparam logic [SRC_W-1:0] SRC_FIRST   = 3'd1;
   localparam logic [SRC_W-1:0] SRC_LAST    = 3'd2;
   localparam logic [SRC_W-1:0] SRC_INTERP  = 3'd3;
   localparam logic [SRC_W-1:0] SRC_HELD    = 3'd4;

   // One keyframe table entry.
   typedef struct packed {
      logic [CURVE_W-1:0] curve;
      logic [VAL_W-1:0]   value;
      logic [TICK_W-1:0]  tick;
   } key_entry_type;

   localparam int ENTRY_W = $bits(key_entry_type);

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_SCAN,
      S_DIV_START,
      S_DIV_WAIT,
      S_MUL_T,
      S_CURVE,
      S_MUL_S,
      S_SMOOTH,
      S_MUL_D,
      S_BLEND,
      S_OUT
   } state_type;

endpackage

>>> hdl/keyframe_curve_evaluator.sv
// Top level of the keyframe curve evaluator: sequencer, shared multiplier and table.
//
// The req channel carries one transaction per item. req_tuser low writes a
// keyframe entry into the table in the accept cycle and gives no response.
// req_tuser high evaluates the curve at query_time and gives one rsp
// transaction holding the value and its source code.
// The csr port writes keys_in_use and the empty-table level, one per cycle.
// An evaluation reads entry 0 and the last entry, then scans the table one
// entry per cycle through the single RAM read port, runs the divider
// for the curve parameter and two to three passes of one shared multiplier.
// An empty table goes from idle straight to the output state, a first-key
// clamp through S_FIRST, a last-key clamp through S_FIRST and S_LAST, and an
// interpolation also through the scan, divide and multiply states. req_tready
// is high only while the sequencer is idle, so an evaluation ends before the
// next request is taken; writes are taken back to back. The finished result
// sits in an output register; if the receiver stalls, the next request is
// still accepted, and its result waits until the held response is taken.
// Reset clears the sequencer, the handshake state and both registers. The
// table has no reset and must be written before it is read.
module keyframe_curve_evaluator (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata from bit 0: key_index[5:0], key_time[31:0], key_value[31:0],
   // key_curve[2:0], query_time[31:0], zero padding.
   input  logic [kce_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: command (0 write, 1 evaluate).
   input  logic                            req_tuser,
   // Response channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata from bit 0: result_value[31:0].
   output logic [kce_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser from bit 0: result_source[2:0].
   output logic [kce_pkg::SRC_W-1:0]       rsp_tuser,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [kce_pkg::CSR_AW-1:0]      csr_addr,
   input  logic [kce_pkg::CSR_DW-1:0]      csr_wdata
);

   // Request fields.
   logic [kce_pkg::KEY_AW-1:0]  key_index;
   logic [kce_pkg::TICK_W-1:0]  key_time;
   logic [kce_pkg::VAL_W-1:0]   key_value;
   logic [kce_pkg::CURVE_W-1:0] key_curve;
   logic [kce_pkg::TICK_W-1:0]  query_time;
   logic                        req_accept;

   assign key_index  = req_tdata[5:0];
   assign key_time   = req_tdata[37:6];
   assign key_value  = req_tdata[69:38];
   assign key_curve  = req_tdata[72:70];
   assign query_time = req_tdata[104:73];
   assign req_accept = req_tvalid & req_tready;

   // Configuration registers.
   logic [kce_pkg::CNT_W-1:0] keys_ff, keys_in;
   logic [kce_pkg::VAL_W-1:0] default_ff, default_in;

   always_comb begin
      keys_in    = keys_ff;
      default_in = default_ff;
      if (csr_we) begin
         case (csr_addr)
            kce_pkg::CSR_KEYS_IN_USE: keys_in    = csr_wdata[kce_pkg::CNT_W-1:0];
            kce_pkg::CSR_EMPTY_LEVEL: default_in = csr_wdata[kce_pkg::VAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer and datapath registers.
   kce_pkg::state_type          state_ff, state_in;
   logic [kce_pkg::TICK_W-1:0]  q_ff, q_in;
   logic [kce_pkg::CNT_W-1:0]   n_ff, n_in;
   logic [kce_pkg::CNT_W-1:0]   ptr_ff, ptr_in;
   kce_pkg::key_entry_type      prev_ff, prev_in;
   logic [kce_pkg::VAL_W-1:0]   v1_ff, v1_in;
   logic [kce_pkg::VAL_W-1:0]   last_ff, last_in;
   logic [kce_pkg::TICK_W-1:0]  span_ff, span_in;
   logic [kce_pkg::TICK_W-1:0]  num_ff, num_in;
   logic [kce_pkg::VAL_W:0]     diff_ff, diff_in;
   logic                        neg_ff, neg_in;
   logic [kce_pkg::VAL_W-1:0]   mag_ff, mag_in;
   logic [kce_pkg::T_W-1:0]     t_ff, t_in;
   logic [kce_pkg::T_W-1:0]     c_ff, c_in;
   logic [kce_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [kce_pkg::VAL_W-1:0]   res_val_ff, res_val_in;
   logic [kce_pkg::SRC_W-1:0]   res_src_ff, res_src_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [kce_pkg::VAL_W-1:0]   rsp_val_ff, rsp_val_in;
   logic [kce_pkg::SRC_W-1:0]   rsp_src_ff, rsp_src_in;

   // Table RAM.
   logic                        ram_we;
   logic [kce_pkg::KEY_AW-1:0]  ram_raddr;
   kce_pkg::key_entry_type      ram_wdata;
   kce_pkg::key_entry_type      cur;
   logic [kce_pkg::ENTRY_W-1:0] ram_rdata;

   assign ram_wdata.tick  = key_time;
   assign ram_wdata.value = key_value;
   assign ram_wdata.curve = key_curve;
   assign cur             = kce_pkg::key_entry_type'(ram_rdata);

   kce_ram #(
      .WIDTH (kce_pkg::ENTRY_W),
      .DEPTH (kce_pkg::MAX_KEYS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (key_index),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Divider for the curve parameter.
   logic                    div_start;
   logic                    div_done;
   logic [kce_pkg::T_W-1:0] div_quo;

   kce_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Shared multiplier.
   logic [kce_pkg::MUL_A_W-1:0] mul_a;
   logic [kce_pkg::MUL_B_W-1:0] mul_b;
   logic [kce_pkg::PROD_W-1:0]  product;
   logic [kce_pkg::T_W-1:0]     base;
   logic [kce_pkg::T_W:0]       mirror;

   assign product = kce_pkg::PROD_W'(mul_a) * kce_pkg::PROD_W'(mul_b);
   assign mirror  = {kce_pkg::ONE, 1'b0} - {t_ff, 1'b0};

   // Base operand of the first shaping square.
   always_comb begin
      case (prev_ff.curve)
         kce_pkg::CURVE_EASE_OUT:    base = kce_pkg::ONE - t_ff;
         kce_pkg::CURVE_EASE_IN_OUT: base = (t_ff < kce_pkg::HALF) ? t_ff
                                            : mirror[kce_pkg::T_W-1:0];
         default:                    base = t_ff;
      endcase
   end

   // Segment bracket test and clamp compares.
   logic                       match;
   logic                       scan_end;
   logic [kce_pkg::CNT_W-1:0]  n_sat;

   assign match    = (q_ff >= prev_ff.tick) && (q_ff <= cur.tick);
   assign scan_end = (ptr_ff == (n_ff - 1'b1));
   assign n_sat    = (keys_ff > kce_pkg::CNT_W'(kce_pkg::MAX_KEYS))
                     ? kce_pkg::CNT_W'(kce_pkg::MAX_KEYS) : keys_ff;

   // Shaped parameter taken from the product register.
   logic [kce_pkg::T_W-1:0] p15, p16, p17, shaped;

   assign p15 = prod_ff[kce_pkg::FRAC_BITS-1 +: kce_pkg::T_W];
   assign p16 = prod_ff[kce_pkg::FRAC_BITS   +: kce_pkg::T_W];
   assign p17 = prod_ff[kce_pkg::FRAC_BITS+1 +: kce_pkg::T_W];

   always_comb begin
      case (prev_ff.curve)
         kce_pkg::CURVE_EASE_IN:     shaped = p16;
         kce_pkg::CURVE_EASE_OUT:    shaped = kce_pkg::ONE - p16;
         kce_pkg::CURVE_EASE_IN_OUT: shaped = (t_ff < kce_pkg::HALF) ? p15
                                              : kce_pkg::ONE - p17;
         default:                    shaped = t_ff;
      endcase
   end

   // Blend step, rounded toward minus infinity for a falling segment.
   logic [kce_pkg::PROD_W-1:0] rounded;
   logic [kce_pkg::VAL_W-1:0]  step;

   assign rounded = neg_ff ? (prod_ff + kce_pkg::PROD_W'(kce_pkg::ONE - 1'b1)) : prod_ff;
   assign step    = rounded[kce_pkg::FRAC_BITS +: kce_pkg::VAL_W];

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kce_pkg::S_IDLE: begin
            if (req_accept && (req_tuser == kce_pkg::CMD_EVAL)) begin
               state_in = (n_sat == '0) ? kce_pkg::S_OUT : kce_pkg::S_FIRST;
            end
         end
         kce_pkg::S_FIRST: begin
            if ((n_ff == kce_pkg::CNT_W'(1)) || (q_ff <= cur.tick)) begin
               state_in = kce_pkg::S_OUT;
            end else begin
               state_in = kce_pkg::S_LAST;
            end
         end
         kce_pkg::S_LAST: begin
            state_in = (q_ff >= cur.tick) ? kce_pkg::S_OUT : kce_pkg::S_SCAN;
         end
         kce_pkg::S_SCAN: begin
            if (match) begin
               state_in = (prev_ff.curve == kce_pkg::CURVE_HOLD) ? kce_pkg::S_OUT
                                                                  : kce_pkg::S_DIV_START;
            end else if (scan_end) begin
               state_in = kce_pkg::S_OUT;
            end
         end
         kce_pkg::S_DIV_START: begin
            state_in = (span_ff == '0) ? kce_pkg::S_MUL_T : kce_pkg::S_DIV_WAIT;
         end
         kce_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               state_in = kce_pkg::S_MUL_T;
            end
         end
         kce_pkg::S_MUL_T: state_in = kce_pkg::S_CURVE;
         kce_pkg::S_CURVE: begin
            state_in = (prev_ff.curve == kce_pkg::CURVE_SMOOTHSTEP) ? kce_pkg::S_MUL_S
                                                                     : kce_pkg::S_MUL_D;
         end
         kce_pkg::S_MUL_S:  state_in = kce_pkg::S_SMOOTH;
         kce_pkg::S_SMOOTH: state_in = kce_pkg::S_MUL_D;
         kce_pkg::S_MUL_D:  state_in = kce_pkg::S_BLEND;
         kce_pkg::S_BLEND:  state_in = kce_pkg::S_OUT;
         kce_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = kce_pkg::S_IDLE;
            end
         end
         default: state_in = kce_pkg::S_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_raddr  = '0;
      div_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         kce_pkg::S_IDLE: begin
            req_tready = 1'b1;
            ram_we     = req_accept && (req_tuser == kce_pkg::CMD_WRITE);
         end
         kce_pkg::S_FIRST: ram_raddr = n_ff[kce_pkg::KEY_AW-1:0] - 1'b1;
         kce_pkg::S_LAST:  ram_raddr = kce_pkg::KEY_AW'(1);
         kce_pkg::S_SCAN: begin
            ram_raddr = ptr_ff[kce_pkg::KEY_AW-1:0] + 1'b1;
         end
         kce_pkg::S_DIV_START: div_start = (span_ff != '0);
         kce_pkg::S_MUL_T: begin
            mul_a = kce_pkg::MUL_A_W'(base);
            mul_b = kce_pkg::MUL_B_W'(base);
         end
         kce_pkg::S_MUL_S: begin
            mul_a = kce_pkg::MUL_A_W'(p16);
            mul_b = kce_pkg::THREE_ONE - {t_ff, 1'b0};
         end
         kce_pkg::S_MUL_D: begin
            mul_a = mag_ff;
            mul_b = kce_pkg::MUL_B_W'(c_ff);
         end
         default: ;
      endcase
   end

   // Datapath register updates.
   always_comb begin
      q_in         = q_ff;
      n_in         = n_ff;
      ptr_in       = ptr_ff;
      prev_in      = prev_ff;
      v1_in        = v1_ff;
      last_in      = last_ff;
      span_in      = span_ff;
      num_in       = num_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      t_in         = t_ff;
      c_in         = c_ff;
      prod_in      = prod_ff;
      res_val_in   = res_val_ff;
      res_src_in   = res_src_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         kce_pkg::S_IDLE: begin
            q_in       = query_time;
            n_in       = n_sat;
            res_val_in = default_ff;
            res_src_in = kce_pkg::SRC_DEFAULT;
         end
         kce_pkg::S_FIRST: begin
            prev_in    = cur;
            res_val_in = cur.value;
            res_src_in = kce_pkg::SRC_FIRST;
         end
         kce_pkg::S_LAST: begin
            last_in    = cur.value;
            ptr_in     = kce_pkg::CNT_W'(1);
            res_val_in = cur.value;
            res_src_in = kce_pkg::SRC_LAST;
         end
         kce_pkg::S_SCAN: begin
            if (match) begin
               v1_in      = cur.value;
               span_in    = cur.tick - prev_ff.tick;
               num_in     = q_ff - prev_ff.tick;
               res_val_in = prev_ff.value;
               res_src_in = kce_pkg::SRC_HELD;
            end else begin
               prev_in    = cur;
               ptr_in     = ptr_ff + 1'b1;
               res_val_in = last_ff;
               res_src_in = kce_pkg::SRC_LAST;
            end
         end
         kce_pkg::S_DIV_START: begin
            t_in    = '0;
            diff_in = {v1_ff[kce_pkg::VAL_W-1], v1_ff}
                      - {prev_ff.value[kce_pkg::VAL_W-1], prev_ff.value};
         end
         kce_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               t_in = div_quo;
            end
         end
         kce_pkg::S_MUL_T: begin
            prod_in = product;
            neg_in  = diff_ff[kce_pkg::VAL_W];
            mag_in  = diff_ff[kce_pkg::VAL_W] ? (~diff_ff[kce_pkg::VAL_W-1:0] + 1'b1)
                                              : diff_ff[kce_pkg::VAL_W-1:0];
         end
         kce_pkg::S_CURVE:  c_in    = shaped;
         kce_pkg::S_MUL_S:  prod_in = product;
         kce_pkg::S_SMOOTH: c_in    = p16;
         kce_pkg::S_MUL_D:  prod_in = product;
         kce_pkg::S_BLEND: begin
            res_val_in = neg_ff ? (prev_ff.value - step) : (prev_ff.value + step);
            res_src_in = kce_pkg::SRC_INTERP;
         end
         kce_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_src_in   = res_src_ff;
            end
         end
         default: ;
      endcase
   end

   // Register bank.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kce_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         keys_ff      <= '0;
         default_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         keys_ff      <= keys_in;
         default_ff   <= default_in;
      end
      q_ff       <= q_in;
      n_ff       <= n_in;
      ptr_ff     <= ptr_in;
      prev_ff    <= prev_in;
      v1_ff      <= v1_in;
      last_ff    <= last_in;
      span_ff    <= span_in;
      num_ff     <= num_in;
      diff_ff    <= diff_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      t_ff       <= t_in;
      c_ff       <= c_in;
      prod_ff    <= prod_in;
      res_val_ff <= res_val_in;
      res_src_ff <= res_src_in;
      rsp_val_ff <= rsp_val_in;
      rsp_src_ff <= rsp_src_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = rsp_src_ff;

endmodule

>>> hdl/kce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/kce_divider.sv
// Restoring divider that forms the curve parameter one quotient bit per cycle.
module kce_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [kce_pkg::TICK_W-1:0] dividend,
   input  logic [kce_pkg::TICK_W-1:0] divisor,
   output logic                       done,
   output logic [kce_pkg::T_W-1:0]    quotient
);

   logic [kce_pkg::TICK_W:0]         rem_ff, rem_in;
   logic [kce_pkg::T_W-1:0]          quo_ff, quo_in;
   logic [kce_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [kce_pkg::TICK_W:0]         trial;
   logic                             fits;
   logic [kce_pkg::TICK_W:0]         kept;

   // One compare-and-subtract step. The dividend never exceeds the divisor, so
   // the first step yields the integer bit and the rest yield fraction bits.
   assign trial = rem_ff - {1'b0, divisor};
   assign fits  = (rem_ff >= {1'b0, divisor});
   assign kept  = fits ? trial : rem_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, dividend};
         quo_in  = '0;
         cnt_in  = kce_pkg::DIV_CNT_W'(kce_pkg::T_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = {kept[kce_pkg::TICK_W-1:0], 1'b0};
         quo_in = {quo_ff[kce_pkg::T_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == kce_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> dv/tb.sv
// Self-checking testbench for the keyframe curve evaluator.
`timescale 1ns / 100ps

module tb;

   localparam int          SETTLE_CYCLES = 100;
   localparam int          STALL_LIMIT   = 20000;
   localparam logic [63:0] UNIT          = 64'(kce_pkg::ONE);

   // One expected response transaction.
   typedef struct packed {
      logic [kce_pkg::VAL_W-1:0] value;
      logic [kce_pkg::SRC_W-1:0] source;
   } curve_sample_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [kce_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = kce_pkg::CMD_WRITE;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [kce_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [kce_pkg::SRC_W-1:0]       rsp_tuser;
   logic                            csr_we     = 1'b0;
   logic [kce_pkg::CSR_AW-1:0]      csr_addr   = kce_pkg::CSR_KEYS_IN_USE;
   logic [kce_pkg::CSR_DW-1:0]      csr_wdata  = '0;

   // Shadow copy of the keyframe table and the registers.
   logic [kce_pkg::TICK_W-1:0]  key_ticks  [kce_pkg::MAX_KEYS];
   logic [kce_pkg::VAL_W-1:0]   key_values [kce_pkg::MAX_KEYS];
   logic [kce_pkg::CURVE_W-1:0] key_curves [kce_pkg::MAX_KEYS];
   logic [6:0]                  active_keys   = '0;
   logic [kce_pkg::VAL_W-1:0]   default_level = '0;

   curve_sample_type pending_samples [$];
   curve_sample_type oldest_sample;
   int               mismatch_count = 0;
   int               items_sent     = 0;
   int               stall_cycles   = 0;
   int unsigned      send_idle_pct  = 0;
   int unsigned      recv_idle_pct  = 0;

   keyframe_curve_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Shape the curve parameter t (unsigned Q1.16, 1.0 = UNIT) by the segment's mode.
   function automatic logic [63:0] ease(input logic [63:0] t,
                                        input logic [kce_pkg::CURVE_W-1:0] mode);
      logic [63:0] u;
      logic [63:0] s;
      case (mode)
         kce_pkg::CURVE_EASE_IN: ease = (t * t) >> kce_pkg::FRAC_BITS;
         kce_pkg::CURVE_EASE_OUT: begin
            u    = UNIT - t;
            ease = UNIT - ((u * u) >> kce_pkg::FRAC_BITS);
         end
         kce_pkg::CURVE_EASE_IN_OUT: begin
            if (t < (UNIT >> 1)) begin
               ease = (t * t) >> (kce_pkg::FRAC_BITS - 1);
            end else begin
               u    = 2 * UNIT - 2 * t;
               ease = UNIT - ((u * u) >> (kce_pkg::FRAC_BITS + 1));
            end
         end
         kce_pkg::CURVE_SMOOTHSTEP: begin
            s    = (t * t) >> kce_pkg::FRAC_BITS;
            ease = (s * (3 * UNIT - 2 * t)) >> kce_pkg::FRAC_BITS;
         end
         default: ease = t;
      endcase
   endfunction

   // Value and source that the curve gives at a query time, from the shadow state.
   function automatic curve_sample_type evaluate_curve(
         input logic [kce_pkg::TICK_W-1:0] query);
      curve_sample_type           r;
      int                         n;
      int                         i;
      logic [kce_pkg::TICK_W-1:0] t0;
      logic [kce_pkg::TICK_W-1:0] t1;
      logic [kce_pkg::TICK_W-1:0] span;
      logic [kce_pkg::TICK_W-1:0] offset;
      logic [63:0]                frac;
      longint                     v0;
      longint                     v1;
      longint                     diff;
      longint                     step;
      n = (active_keys > kce_pkg::MAX_KEYS) ? kce_pkg::MAX_KEYS : int'(active_keys);
      if (n == 0) begin
         r = '{default_level, kce_pkg::SRC_DEFAULT};
      end else if (n == 1 || query <= key_ticks[0]) begin
         r = '{key_values[0], kce_pkg::SRC_FIRST};
      end else if (query >= key_ticks[n-1]) begin
         r = '{key_values[n-1], kce_pkg::SRC_LAST};
      end else begin
         r = '{key_values[n-1], kce_pkg::SRC_LAST};
         for (i = 0; i + 1 < n; i++) begin
            t0 = key_ticks[i];
            t1 = key_ticks[i+1];
            if (query >= t0 && query <= t1) begin
               if (key_curves[i] == kce_pkg::CURVE_HOLD) begin
                  r = '{key_values[i], kce_pkg::SRC_HELD};
               end else begin
                  span   = t1 - t0;
                  offset = query - t0;
                  frac   = 0;
                  if (span != 0) begin
                     frac = ({32'd0, offset} << kce_pkg::FRAC_BITS) / {32'd0, span};
                     if (frac > UNIT) frac = UNIT;
                  end
                  frac = ease(frac, key_curves[i]);
                  v0   = $signed(key_values[i]);
                  v1   = $signed(key_values[i+1]);
                  diff = v1 - v0;
                  // The step rounds toward minus infinity in both directions.
                  if (diff >= 0) begin
                     step = (diff * longint'(frac)) >>> kce_pkg::FRAC_BITS;
                  end else begin
                     step = -(((-diff) * longint'(frac) + longint'(UNIT) - 1)
                              >>> kce_pkg::FRAC_BITS);
                  end
                  r = '{32'(v0 + step), kce_pkg::SRC_INTERP};
               end
               break;
            end
         end
      end
      return r;
   endfunction

   // Send one request transaction and update the shadow state when it is accepted.
   task automatic send_item(input logic cmd, input logic [5:0] idx,
                            input logic [kce_pkg::TICK_W-1:0] ktime,
                            input logic [kce_pkg::VAL_W-1:0] kval,
                            input logic [kce_pkg::CURVE_W-1:0] kcurve,
                            input logic [kce_pkg::TICK_W-1:0] qtime);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, qtime, kcurve, kval, ktime, idx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (cmd == kce_pkg::CMD_WRITE) begin
         key_ticks[idx]  = ktime;
         key_values[idx] = kval;
         key_curves[idx] = kcurve;
      end else begin
         pending_samples.push_back(evaluate_curve(qtime));
      end
      items_sent++;
   endtask

   // Hold off the sender until every response is in and the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers once the block is idle. Bits above the key count are junk.
   task automatic set_config(input logic [6:0] keys, input logic [kce_pkg::VAL_W-1:0] dflt);
      logic [kce_pkg::CSR_DW-1:0] junk;
      junk = $urandom;
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= kce_pkg::CSR_KEYS_IN_USE;
      csr_wdata <= {junk[kce_pkg::CSR_DW-1:7], keys};
      @(posedge clock);
      active_keys = keys;
      csr_addr  <= kce_pkg::CSR_EMPTY_LEVEL;
      csr_wdata <= dflt;
      @(posedge clock);
      default_level = dflt;
      csr_we <= 1'b0;
   endtask

   // An empty table answers the default register at any time.
   task automatic test_empty_table();
      set_config(7'd0, 32'h8000_0000);
      send_item(kce_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h0000_0000);
      send_item(kce_pkg::CMD_EVAL, '1, '1, '1, '1, 32'hFFFF_FFFF);
      set_config(7'd0, 32'h7FFF_FFFF);
      send_item(kce_pkg::CMD_EVAL, 6'h2A, $urandom, $urandom, '0, 32'h8000_0000);
   endtask

   // A single key answers its own value even where its curve is hold.
   task automatic test_single_key();
      send_item(kce_pkg::CMD_WRITE, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                kce_pkg::CURVE_HOLD, '1);
      set_config(7'd1, 32'h0000_0000);
      send_item(kce_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h0000_0000);
      send_item(kce_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h8000_0000);
      send_item(kce_pkg::CMD_EVAL, '0, '0, '0, '0, 32'hFFFF_FFFF);
   endtask

   // Nine keys spread over the whole time range, one segment per curve code,
   // with values swinging between the extremes. A zero-length segment past the
   // first key never brackets a query, since the segment before it always does.
   task automatic test_curve_modes();
      int                         i;
      logic [kce_pkg::TICK_W-1:0] span;
      for (i = 0; i < 9; i++) begin
         send_item(kce_pkg::CMD_WRITE, 6'(i), (i == 8) ? 32'hFFFF_FFFF : 32'(i) << 29,
                   (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF, 3'(i), $urandom);
      end
      set_config(7'd9, $urandom);
      for (i = 0; i < 8; i++) begin
         span = key_ticks[i+1] - key_ticks[i];
         send_item(kce_pkg::CMD_EVAL, 6'($urandom), $urandom, $urandom, 3'($urandom),
                   key_ticks[i] + (span / 4) * 3);
      end
      // Lower half of ease-in-out, an interior key, and both clamps.
      send_item(kce_pkg::CMD_EVAL, '0, '0, '0, '0,
                key_ticks[3] + (key_ticks[4] - key_ticks[3]) / 4);
      send_item(kce_pkg::CMD_EVAL, '0, '0, '0, '0, key_ticks[1]);
      send_item(kce_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h0000_0000);
      send_item(kce_pkg::CMD_EVAL, '0, '0, '0, '0, 32'hFFFF_FFFF);
   endtask

   // Rounds of a freshly written sorted table followed by evaluations, with a few
   // stray writes that can break the ordering. Runs until the item count is reached.
   task automatic test_random_tables(input int target);
      int unsigned                n;
      int unsigned                pick;
      int unsigned                evals;
      int                         i;
      int                         e;
      logic [6:0]                 keys_code;
      logic [kce_pkg::TICK_W-1:0] tick;
      logic [kce_pkg::TICK_W-1:0] gap_max;
      logic [kce_pkg::TICK_W-1:0] lo;
      logic [kce_pkg::TICK_W-1:0] hi;
      logic [kce_pkg::TICK_W-1:0] q;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 5) n = 0;
         else if (pick < 12) n = 1;
         else if (pick < 20) n = kce_pkg::MAX_KEYS;
         else if (pick < 60) n = $urandom_range(4, 2);
         else n = $urandom_range(16, 5);
         keys_code = 7'(n);
         // A count past the table size saturates.
         if (n == kce_pkg::MAX_KEYS && $urandom_range(1) == 1) begin
            keys_code = 7'($urandom_range(127, 65));
         end
         set_config(keys_code, $urandom);

         // Sorted key times; some spans are tiny or zero.
         if (n > 0) begin
            gap_max = 32'hFFFF_FFFF / n;
            tick    = $urandom_range(gap_max);
            for (i = 0; i < int'(n); i++) begin
               if (i > 0) begin
                  tick += ($urandom_range(3) == 0) ? $urandom_range(4) : $urandom_range(gap_max);
               end
               send_item(kce_pkg::CMD_WRITE, 6'(i), tick, $urandom,
                         3'($urandom_range(7)), $urandom);
            end
         end

         evals = $urandom_range(30, 8);
         for (e = 0; e < int'(evals); e++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               send_item(kce_pkg::CMD_WRITE, 6'($urandom), $urandom, $urandom,
                         3'($urandom), $urandom);
            end else begin
               if (n >= 2 && pick < 65) begin
                  i  = $urandom_range(n - 2);
                  lo = key_ticks[i];
                  hi = key_ticks[i+1];
                  q  = (hi >= lo) ? lo + $urandom_range(hi - lo) : $urandom;
               end else if (n >= 1 && pick < 80) begin
                  q = key_ticks[$urandom_range(n - 1)];
               end else if (pick < 88) begin
                  q = ($urandom_range(1) == 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
               end else begin
                  q = $urandom;
               end
               send_item(kce_pkg::CMD_EVAL, 6'($urandom), $urandom, $urandom,
                         3'($urandom), q);
            end
         end
      end
   endtask

   // Compare each response transaction with the oldest expected sample.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_samples.size() == 0) begin
               $display("%0t: unexpected response value %h source %0d",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               oldest_sample = pending_samples.pop_front();
               if (rsp_tdata !== oldest_sample.value) begin
                  $display("%0t: value expected %h actual %h",
                           $time, oldest_sample.value, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== oldest_sample.source) begin
                  $display("%0t: source expected %0d actual %0d",
                           $time, oldest_sample.source, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 76;
      test_empty_table();
      test_single_key();
      test_curve_modes();
      test_random_tables(400);

      send_idle_pct = 76;
      recv_idle_pct = 37;
      test_random_tables(750);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_tables(1100);

      settle();
      if (mismatch_count == 0 && pending_samples.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
